[design/alrc_pkg.sv]
package alrc_pkg;

   localparam int SIZE_W  = 31;
   localparam int RATIO_W = 8;
   localparam int ACC_W   = 40;
   localparam int PROD_W  = SIZE_W + RATIO_W;
   localparam int CNT_W   = 4;
   localparam int PC_W    = 4;

   localparam logic [RATIO_W-1:0] RATIO_FULL = 8'd255;

   // Quotient bits minus one for the ratio division loop.
   localparam logic [CNT_W-1:0] ENC_DIV_LAST = 4'd8;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_MUL255,
      DP_ADDBIAS,
      DP_DIVSTEP,
      DP_SATRATIO,
      DP_ZERORATIO,
      DP_DECRATIO,
      DP_MULRATIO,
      DP_FOLD255,
      DP_SHRINK
   } dp_op_type;

   typedef enum logic [2:0] {
      CND_NEXT,
      CND_ALWAYS,
      CND_DECODE,
      CND_REM_ZERO,
      CND_CNT_NZ,
      CND_ACC_BIG
   } cond_type;

   typedef struct packed {
      dp_op_type        op;
      cond_type         cond;
      logic [PC_W-1:0]  target;
      logic             done;
   } uword_type;

   typedef struct packed {
      logic is_decode;
      logic rem_zero;
      logic cnt_nz;
      logic acc_big;
   } flags_type;

   typedef struct packed {
      logic      exec;
      logic      done;
      dp_op_type op;
   } seq_ctrl_type;

   localparam logic [PC_W-1:0] PC_ENTRY      = 4'd0;
   localparam logic [PC_W-1:0] PC_ENC_CHECK  = 4'd1;
   localparam logic [PC_W-1:0] PC_ENC_MUL    = 4'd2;
   localparam logic [PC_W-1:0] PC_ENC_BIAS   = 4'd3;
   localparam logic [PC_W-1:0] PC_ENC_DIV    = 4'd4;
   localparam logic [PC_W-1:0] PC_ENC_SAT    = 4'd5;
   localparam logic [PC_W-1:0] PC_ZERO_RATIO = 4'd6;
   localparam logic [PC_W-1:0] PC_DEC_RATIO  = 4'd7;
   localparam logic [PC_W-1:0] PC_SHR_MUL    = 4'd8;
   localparam logic [PC_W-1:0] PC_SHR_DIV    = 4'd9;
   localparam logic [PC_W-1:0] PC_SHR_DONE   = 4'd10;

   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type w;
      w = '{op: DP_NOP, cond: CND_NEXT, target: PC_ENTRY, done: 1'b1};
      case (pc)
         PC_ENTRY:      w = '{DP_NOP,       CND_DECODE,   PC_DEC_RATIO,  1'b0};
         PC_ENC_CHECK:  w = '{DP_NOP,       CND_REM_ZERO, PC_ZERO_RATIO, 1'b0};
         PC_ENC_MUL:    w = '{DP_MUL255,    CND_NEXT,     PC_ENTRY,      1'b0};
         PC_ENC_BIAS:   w = '{DP_ADDBIAS,   CND_NEXT,     PC_ENTRY,      1'b0};
         PC_ENC_DIV:    w = '{DP_DIVSTEP,   CND_CNT_NZ,   PC_ENC_DIV,    1'b0};
         PC_ENC_SAT:    w = '{DP_SATRATIO,  CND_ALWAYS,   PC_SHR_MUL,    1'b0};
         PC_ZERO_RATIO: w = '{DP_ZERORATIO, CND_ALWAYS,   PC_SHR_MUL,    1'b0};
         PC_DEC_RATIO:  w = '{DP_DECRATIO,  CND_NEXT,     PC_ENTRY,      1'b0};
         PC_SHR_MUL:    w = '{DP_MULRATIO,  CND_NEXT,     PC_ENTRY,      1'b0};
         PC_SHR_DIV:    w = '{DP_FOLD255,   CND_ACC_BIG,  PC_SHR_DIV,    1'b0};
         PC_SHR_DONE:   w = '{DP_SHRINK,    CND_NEXT,     PC_ENTRY,      1'b1};
         default:       w = '{DP_NOP,       CND_NEXT,     PC_ENTRY,      1'b1};
      endcase
      return w;
   endfunction

endpackage

[design/adaptive_level_ratio_codec_unit.sv]
// Level ratio codec: each request beat codes one wavelet level of a chunk, encoding a level
// size into a ratio byte of the running remaining size or decoding a ratio byte back into a
// level size, with first reloading the remaining size from the total size. The block works on
// one beat at a time; once its result is valid, the next request is taken. The time is set
// by the microcode: a restoring divider by the remaining size takes nine iterations for the
// ratio quotient, and the division of the scaled remaining size by 255 folds base-256
// digits, which takes one to six steps depending on the value. A finished result waits in
// the output register while the next beat is worked on.
module adaptive_level_ratio_codec_unit
   import alrc_pkg::*;
#(
   parameter int LEVEL_COUNT = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic               req_first,
   input  logic [SIZE_W-1:0]  req_total_size,
   input  logic [SIZE_W-1:0]  req_level_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [SIZE_W-1:0]  rsp_result_value,
   output logic               rsp_last
);

   logic               busy;
   logic               start;
   logic               out_blocked;
   seq_ctrl_type       ctrl;
   flags_type          flags;
   logic [SIZE_W-1:0]  result_value;
   logic               result_last;
   logic               finish;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [SIZE_W-1:0]  rsp_result_value_ff, rsp_result_value_in;
   logic               rsp_last_ff, rsp_last_in;

   assign req_ready   = !busy;
   assign start       = req_valid && !busy;
   assign out_blocked = rsp_valid_ff && !rsp_ready;
   assign finish      = ctrl.exec && ctrl.done;

   alrc_useq u_useq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .out_blocked (out_blocked),
      .flags       (flags),
      .busy        (busy),
      .ctrl        (ctrl)
   );

   alrc_datapath #(
      .LEVEL_COUNT (LEVEL_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .load           (start),
      .in_opcode      (req_opcode),
      .in_first       (req_first),
      .in_total_size  (req_total_size),
      .in_level_value (req_level_value),
      .ctrl           (ctrl),
      .flags          (flags),
      .result_value   (result_value),
      .result_last    (result_last)
   );

   always_comb begin
      rsp_valid_in        = rsp_valid_ff;
      rsp_result_value_in = rsp_result_value_ff;
      rsp_last_in         = rsp_last_ff;
      if (finish) begin
         rsp_valid_in        = 1'b1;
         rsp_result_value_in = result_value;
         rsp_last_in         = result_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_value_ff <= rsp_result_value_in;
      rsp_last_ff         <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_result_value_ff;
   assign rsp_last         = rsp_last_ff;

   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      finish |-> !(rsp_valid_ff && !rsp_ready))
      else $error("Result would overwrite a beat not yet taken.");

endmodule

[design/alrc_useq.sv]
module alrc_useq
   import alrc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         out_blocked,
   input  flags_type    flags,
   output logic         busy,
   output seq_ctrl_type ctrl
);

   logic            busy_ff, busy_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   uword_type       uword;
   logic            taken;
   logic            exec;

   always_comb begin
      uword = ucode_rom(pc_ff);
      case (uword.cond)
         CND_NEXT:     taken = 1'b0;
         CND_ALWAYS:   taken = 1'b1;
         CND_DECODE:   taken = flags.is_decode;
         CND_REM_ZERO: taken = flags.rem_zero;
         CND_CNT_NZ:   taken = flags.cnt_nz;
         CND_ACC_BIG:  taken = flags.acc_big;
         default:      taken = 1'b0;
      endcase

      exec    = busy_ff && !(uword.done && out_blocked);
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = PC_ENTRY;
      end else if (exec) begin
         if (uword.done) begin
            busy_in = 1'b0;
         end else if (taken) begin
            pc_in = uword.target;
         end else begin
            pc_in = pc_ff + PC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= PC_ENTRY;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign busy      = busy_ff;
   assign ctrl.exec = exec;
   assign ctrl.done = uword.done;
   assign ctrl.op   = uword.op;

   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pc_ff <= PC_SHR_DONE))
      else $error("Step counter has left the program.");

   a_start_only_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("Beat accepted while the sequencer was busy.");

endmodule

[design/alrc_datapath.sv]
module alrc_datapath
   import alrc_pkg::*;
#(
   parameter int LEVEL_COUNT = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic               in_opcode,
   input  logic               in_first,
   input  logic [SIZE_W-1:0]  in_total_size,
   input  logic [SIZE_W-1:0]  in_level_value,
   input  seq_ctrl_type       ctrl,
   output flags_type          flags,
   output logic [SIZE_W-1:0]  result_value,
   output logic               result_last
);

   localparam int LW = $clog2(LEVEL_COUNT);

   logic [SIZE_W-1:0]  rem_ff, rem_in;
   logic [LW-1:0]      level_ff, level_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [ACC_W-1:0]   dsh_ff, dsh_in;
   logic [SIZE_W-1:0]  quo_ff, quo_in;
   logic [RATIO_W-1:0] ratio_ff, ratio_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SIZE_W-1:0]  val_ff, val_in;
   logic               opc_ff, opc_in;
   logic               last_ff, last_in;

   logic [LW-1:0]      idx;
   logic [ACC_W:0]     diff;
   logic               ge;
   logic [PROD_W-1:0]  prod;
   logic [SIZE_W-1:0]  shrunk;

   always_comb begin
      rem_in   = rem_ff;
      level_in = level_ff;
      acc_in   = acc_ff;
      dsh_in   = dsh_ff;
      quo_in   = quo_ff;
      ratio_in = ratio_ff;
      cnt_in   = cnt_ff;
      val_in   = val_ff;
      opc_in   = opc_ff;
      last_in  = last_ff;

      idx    = in_first ? '0 : level_ff;
      diff   = {1'b0, acc_ff} - {1'b0, dsh_ff};
      ge     = !diff[ACC_W];
      prod   = PROD_W'(rem_ff) * PROD_W'(ratio_ff);
      shrunk = quo_ff + {{(SIZE_W - 1){1'b0}}, (acc_ff[RATIO_W-1:0] == RATIO_FULL)};

      if (load) begin
         if (in_first) begin
            rem_in = in_total_size;
         end
         last_in  = (idx == LW'(LEVEL_COUNT - 1));
         level_in = last_in ? '0 : idx + LW'(1);
         val_in   = in_level_value;
         opc_in   = in_opcode;
      end else if (ctrl.exec) begin
         case (ctrl.op)
            DP_NOP: begin
            end
            DP_MUL255: begin
               acc_in = {1'b0, val_ff, 8'b0} - {9'b0, val_ff};
            end
            DP_ADDBIAS: begin
               acc_in = acc_ff + {9'b0, rem_ff} - ACC_W'(1);
               dsh_in = {1'b0, rem_ff, 8'b0};
               cnt_in = ENC_DIV_LAST;
               quo_in = '0;
            end
            DP_DIVSTEP: begin
               if (ge) begin
                  acc_in = diff[ACC_W-1:0];
               end
               quo_in = {quo_ff[SIZE_W-2:0], ge};
               dsh_in = dsh_ff >> 1;
               cnt_in = cnt_ff - CNT_W'(1);
            end
            DP_SATRATIO: begin
               ratio_in = quo_ff[RATIO_W] ? RATIO_FULL : quo_ff[RATIO_W-1:0];
            end
            DP_ZERORATIO: begin
               ratio_in = '0;
            end
            DP_DECRATIO: begin
               ratio_in = val_ff[RATIO_W-1:0];
            end
            DP_MULRATIO: begin
               acc_in = {1'b0, prod};
               quo_in = '0;
            end
            // With x = 256a + b = 255a + (a + b), a joins the quotient and a + b carries on.
            DP_FOLD255: begin
               acc_in = {{RATIO_W{1'b0}}, acc_ff[ACC_W-1:RATIO_W]}
                      + {{(ACC_W - RATIO_W){1'b0}}, acc_ff[RATIO_W-1:0]};
               quo_in = quo_ff + acc_ff[SIZE_W+RATIO_W-1:RATIO_W];
            end
            DP_SHRINK: begin
               rem_in = shrunk;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= '0;
         level_ff <= '0;
      end else begin
         rem_ff   <= rem_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      dsh_ff   <= dsh_in;
      quo_ff   <= quo_in;
      ratio_ff <= ratio_in;
      cnt_ff   <= cnt_in;
      val_ff   <= val_in;
      opc_ff   <= opc_in;
      last_ff  <= last_in;
   end

   assign flags.is_decode = opc_ff;
   assign flags.rem_zero  = (rem_ff == '0);
   assign flags.cnt_nz    = (cnt_ff != '0);
   assign flags.acc_big   = |acc_ff[ACC_W-1:RATIO_W];

   assign result_value = opc_ff ? shrunk : {{(SIZE_W - RATIO_W){1'b0}}, ratio_ff};
   assign result_last  = last_ff;

   a_remaining_never_grows: assert property (@(posedge clock) disable iff (reset)
      (ctrl.exec && ctrl.op == DP_SHRINK && !load) |-> (shrunk <= rem_ff))
      else $error("Remaining size would grow on shrink.");

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(LEVEL_COUNT - 1))
      else $error("Level index beyond the last level.");

endmodule
